// ===== hdl/rcsp_pkg.sv =====
// Shared constants, codes and control/status types for the receipt command stream parser.
`default_nettype none

package rcsp_pkg;

    localparam int LINE_CHARS_DEF = 48;
    localparam int FILL_W         = 6;

    // result event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_CHAR = 2'd1;
    localparam logic [1:0] EV_DONE = 2'd2;
    localparam logic [1:0] EV_CUT  = 2'd3;

    // stream bytes
    localparam logic [7:0] B_ESC   = 8'h1B;
    localparam logic [7:0] B_GS    = 8'h1D;
    localparam logic [7:0] B_DLE   = 8'h10;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] B_FF    = 8'h0C;
    localparam logic [7:0] B_SPACE = 8'h20;
    localparam logic [7:0] B_TILDE = 8'h7E;
    localparam logic [7:0] B_NUL   = 8'h00;
    localparam logic [7:0] B_CUT_A = 8'h41;
    localparam logic [7:0] B_CUT_B = 8'h42;
    localparam logic [7:0] B_PAREN = 8'h28;
    localparam logic [7:0] B_BARCD = 8'h6B;
    localparam logic [7:0] B_CUTCM = 8'h56;
    localparam logic [7:0] B_PULSE = 8'h70;
    localparam logic [7:0] B_INIT  = 8'h40;
    localparam logic [7:0] B_FEED  = 8'h64;

    // parser state codes
    localparam logic [3:0] PS_NORMAL     = 4'd0;
    localparam logic [3:0] PS_ESC        = 4'd1;
    localparam logic [3:0] PS_GS         = 4'd2;
    localparam logic [3:0] PS_DLE        = 4'd3;
    localparam logic [3:0] PS_SKIP       = 4'd4;
    localparam logic [3:0] PS_ESC_P      = 4'd5;
    localparam logic [3:0] PS_ESC_P2     = 4'd6;
    localparam logic [3:0] PS_GS_V       = 4'd7;
    localparam logic [3:0] PS_GS_V_PARAM = 4'd8;
    localparam logic [3:0] PS_GS_K       = 4'd9;
    localparam logic [3:0] PS_GS_K_LEN   = 4'd10;
    localparam logic [3:0] PS_GS_K_DATA  = 4'd11;
    localparam logic [3:0] PS_PAREN_LO   = 4'd12;
    localparam logic [3:0] PS_PAREN_HI   = 4'd13;
    localparam logic [3:0] PS_PAREN_DATA = 4'd14;

    typedef struct packed {
        logic       accept;   // take the input request, update parser state
        logic       idx_clr;  // restart the line read index
        logic       rd;       // read line buffer at the index
        logic       load;     // load the output register
        logic [1:0] ev;       // event for the load
        logic       last;     // last flag for the load
    } ctrl_cmd_t;

    typedef struct packed {
        logic commit;    // request commits the line
        logic cut;       // request ends in a cut event
        logic len_nz;    // trimmed line is non-empty
        logic idx_last;  // current index is the final character
        logic out_free;  // output register can be loaded
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/rcsp_datapath.sv =====
// Parser state, line buffer, trim tracking and output register.
`default_nettype none

module rcsp_datapath #(
    parameter int LINE_CHARS = rcsp_pkg::LINE_CHARS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      mode,
    input  wire logic [7:0]                in_byte,
    input  wire logic                      out_stall,
    input  wire rcsp_pkg::ctrl_cmd_t       cmd,
    output rcsp_pkg::dp_status_t           status,
    output logic                           out_valid,
    output logic [1:0]                     event_res,
    output logic [6:0]                     char_value,
    output logic [rcsp_pkg::FILL_W-1:0]    line_length,
    output logic                           last
);

    localparam int IDX_W = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
    localparam logic [rcsp_pkg::FILL_W-1:0] LC_W = rcsp_pkg::FILL_W'(LINE_CHARS);

    logic [3:0]                   pstate_reg, pstate_next;
    logic [15:0]                  skip_reg, skip_next;
    logic [7:0]                   bc_reg, bc_next;
    logic [rcsp_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [rcsp_pkg::FILL_W-1:0]  trim_reg, trim_next;
    logic [rcsp_pkg::FILL_W-1:0]  len_reg, len_next;
    logic [rcsp_pkg::FILL_W-1:0]  idx_reg, idx_next;
    logic [6:0]                   rd_data_reg;
    logic [6:0]                   line_mem [LINE_CHARS];

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   ev_reg;
    logic [6:0]                   ch_reg;
    logic [rcsp_pkg::FILL_W-1:0]  olen_reg;
    logic                         last_reg;

    logic        dec_commit, dec_flush, dec_cut, dec_append;
    logic [15:0] skip_dec;
    logic [7:0]  bc_dec;
    logic        commit;

    assign skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : skip_reg;
    assign bc_dec   = bc_reg - 8'd1;

    // one stream byte through the parser
    always_comb
    begin
        pstate_next = pstate_reg;
        skip_next   = skip_reg;
        bc_next     = bc_reg;
        dec_commit  = 1'b0;
        dec_flush   = 1'b0;
        dec_cut     = 1'b0;
        dec_append  = 1'b0;
        if (mode)
        begin
            dec_flush = 1'b1;
        end
        else
        begin
            case (pstate_reg)
                rcsp_pkg::PS_ESC:
                begin
                    case (in_byte)
                        8'h20, 8'h21, 8'h2D, 8'h45, 8'h47, 8'h4A, 8'h4D, 8'h52,
                        8'h53, 8'h56, 8'h61, 8'h63, 8'h74, 8'h75, 8'h77, 8'h7B:
                        begin
                            skip_next   = 16'd1;
                            pstate_next = rcsp_pkg::PS_SKIP;
                        end
                        rcsp_pkg::B_FEED:
                        begin
                            dec_flush   = 1'b1;
                            skip_next   = 16'd1;
                            pstate_next = rcsp_pkg::PS_SKIP;
                        end
                        rcsp_pkg::B_PULSE: pstate_next = rcsp_pkg::PS_ESC_P;
                        default:           pstate_next = rcsp_pkg::PS_NORMAL;
                    endcase
                end
                rcsp_pkg::PS_GS:
                begin
                    case (in_byte)
                        8'h21, 8'h42, 8'h68, 8'h77, 8'h48, 8'h66, 8'h72:
                        begin
                            skip_next   = 16'd1;
                            pstate_next = rcsp_pkg::PS_SKIP;
                        end
                        8'h4C, 8'h57, 8'h50:
                        begin
                            skip_next   = 16'd2;
                            pstate_next = rcsp_pkg::PS_SKIP;
                        end
                        rcsp_pkg::B_CUTCM: pstate_next = rcsp_pkg::PS_GS_V;
                        rcsp_pkg::B_BARCD: pstate_next = rcsp_pkg::PS_GS_K;
                        rcsp_pkg::B_PAREN: pstate_next = rcsp_pkg::PS_PAREN_LO;
                        default:           pstate_next = rcsp_pkg::PS_NORMAL;
                    endcase
                end
                rcsp_pkg::PS_DLE, rcsp_pkg::PS_ESC_P2:
                    pstate_next = rcsp_pkg::PS_NORMAL;
                rcsp_pkg::PS_ESC_P:
                    pstate_next = rcsp_pkg::PS_ESC_P2;
                rcsp_pkg::PS_SKIP, rcsp_pkg::PS_PAREN_DATA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        pstate_next = rcsp_pkg::PS_NORMAL;
                end
                rcsp_pkg::PS_GS_V:
                begin
                    dec_flush = 1'b1;
                    if (in_byte == rcsp_pkg::B_CUT_A || in_byte == rcsp_pkg::B_CUT_B)
                        pstate_next = rcsp_pkg::PS_GS_V_PARAM;
                    else
                    begin
                        pstate_next = rcsp_pkg::PS_NORMAL;
                        dec_cut     = 1'b1;
                    end
                end
                rcsp_pkg::PS_GS_V_PARAM:
                begin
                    pstate_next = rcsp_pkg::PS_NORMAL;
                    dec_cut     = 1'b1;
                end
                rcsp_pkg::PS_GS_K:
                begin
                    if (in_byte >= rcsp_pkg::B_CUT_A)
                        pstate_next = rcsp_pkg::PS_GS_K_LEN;
                    else
                    begin
                        bc_next     = 8'd0;
                        pstate_next = rcsp_pkg::PS_GS_K_DATA;
                    end
                end
                rcsp_pkg::PS_GS_K_LEN:
                begin
                    bc_next     = in_byte;
                    pstate_next = rcsp_pkg::PS_GS_K_DATA;
                end
                rcsp_pkg::PS_GS_K_DATA:
                begin
                    if (bc_reg != 8'd0)
                    begin
                        bc_next = bc_dec;
                        if (bc_dec == 8'd0)
                            pstate_next = rcsp_pkg::PS_NORMAL;
                    end
                    else if (in_byte == rcsp_pkg::B_NUL)
                        pstate_next = rcsp_pkg::PS_NORMAL;
                end
                rcsp_pkg::PS_PAREN_LO:
                begin
                    skip_next   = {8'd0, in_byte};
                    pstate_next = rcsp_pkg::PS_PAREN_HI;
                end
                rcsp_pkg::PS_PAREN_HI:
                begin
                    skip_next   = skip_reg + {in_byte, 8'd0};
                    pstate_next = (skip_next != 16'd0) ? rcsp_pkg::PS_PAREN_DATA
                                                       : rcsp_pkg::PS_NORMAL;
                end
                default:
                begin
                    pstate_next = rcsp_pkg::PS_NORMAL;
                    if (in_byte == rcsp_pkg::B_ESC)
                        pstate_next = rcsp_pkg::PS_ESC;
                    else if (in_byte == rcsp_pkg::B_GS)
                        pstate_next = rcsp_pkg::PS_GS;
                    else if (in_byte == rcsp_pkg::B_DLE)
                        pstate_next = rcsp_pkg::PS_DLE;
                    else if (in_byte == rcsp_pkg::B_LF || in_byte == rcsp_pkg::B_CR ||
                             in_byte == rcsp_pkg::B_FF)
                        dec_commit = 1'b1;
                    else if (in_byte >= rcsp_pkg::B_SPACE && in_byte <= rcsp_pkg::B_TILDE)
                        dec_append = (fill_reg < LC_W);
                end
            endcase
        end
    end

    assign commit = dec_commit || (dec_flush && fill_reg != '0);

    // trim_reg follows the length up to the last non-space character
    always_comb
    begin
        fill_next = fill_reg;
        trim_next = trim_reg;
        len_next  = len_reg;
        if (commit)
        begin
            fill_next = '0;
            trim_next = '0;
            len_next  = trim_reg;
        end
        else if (dec_append)
        begin
            fill_next = fill_reg + rcsp_pkg::FILL_W'(1);
            if (in_byte != rcsp_pkg::B_SPACE)
                trim_next = fill_reg + rcsp_pkg::FILL_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.load && cmd.ev == rcsp_pkg::EV_CHAR)
            idx_next = idx_reg + rcsp_pkg::FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstate_reg <= rcsp_pkg::PS_NORMAL;
            skip_reg   <= 16'd0;
            bc_reg     <= 8'd0;
            fill_reg   <= '0;
            trim_reg   <= '0;
            len_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                pstate_reg <= pstate_next;
                skip_reg   <= skip_next;
                bc_reg     <= bc_next;
                fill_reg   <= fill_next;
                trim_reg   <= trim_next;
                len_reg    <= len_next;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && dec_append)
            line_mem[fill_reg[IDX_W-1:0]] <= in_byte[6:0];
        if (cmd.rd)
            rd_data_reg <= line_mem[idx_reg[IDX_W-1:0]];
    end

    // output register
    assign out_valid_next = cmd.load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ev_reg   <= cmd.ev;
            ch_reg   <= (cmd.ev == rcsp_pkg::EV_CHAR) ? rd_data_reg : 7'd0;
            olen_reg <= (cmd.ev == rcsp_pkg::EV_DONE) ? len_reg : '0;
            last_reg <= cmd.last;
        end
    end

    assign status.commit   = commit;
    assign status.cut      = dec_cut;
    assign status.len_nz   = (trim_reg != '0);
    assign status.idx_last = ((idx_reg + rcsp_pkg::FILL_W'(1)) == len_reg);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign char_value  = ch_reg;
    assign line_length = olen_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== hdl/rcsp_ctrl.sv =====
// Sequencer that accepts requests and steps result emission.
`default_nettype none

module rcsp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire rcsp_pkg::dp_status_t  status,
    output rcsp_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CHAR = 6'b000100,
        S_DONE = 6'b001000,
        S_CUT  = 6'b010000,
        S_NONE = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        cut_reg, cut_next;

    always_comb
    begin
        state_next  = state_reg;
        cut_next    = cut_reg;
        cmd         = '0;
        cmd.ev      = rcsp_pkg::EV_NONE;
        in_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    cut_next    = status.cut;
                    if (status.commit && status.len_nz)
                        state_next = S_READ;
                    else if (status.commit)
                        state_next = S_DONE;
                    else if (status.cut)
                        state_next = S_CUT;
                    else
                        state_next = S_NONE;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHAR;
            end
            S_CHAR:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.ev     = rcsp_pkg::EV_CHAR;
                    state_next = status.idx_last ? S_DONE : S_READ;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.ev     = rcsp_pkg::EV_DONE;
                    cmd.last   = !cut_reg;
                    state_next = cut_reg ? S_CUT : S_IDLE;
                end
            end
            S_CUT:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.ev     = rcsp_pkg::EV_CUT;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.ev     = rcsp_pkg::EV_NONE;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cut_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cut_reg   <= cut_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/receipt_command_stream_parser.sv =====
// Sequence: a request is taken in the idle state; without a line commit it loads a single
// result (none or cut) into the output register, then returns to idle. A line commit of N
// kept characters steps, per character, through a line-buffer read state and a load state,
// then loads the done result and, if the request ends in a cut, a cut result. The block is
// busy until its last result is loaded. Output backpressure holds each load.
// Reset (async, rst_n low): parser back to text state, line empty, no result pending.
`default_nettype none

module receipt_command_stream_parser #(
    parameter int LINE_CHARS = rcsp_pkg::LINE_CHARS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      mode,
    input  wire logic [7:0]                in_byte,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     event_res,
    output logic [6:0]                     char_value,
    output logic [rcsp_pkg::FILL_W-1:0]    line_length,
    output logic                           last
);

    rcsp_pkg::ctrl_cmd_t  cmd;
    rcsp_pkg::dp_status_t status;

    rcsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rcsp_datapath #(
        .LINE_CHARS (LINE_CHARS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .in_byte     (in_byte),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .event_res   (event_res),
        .char_value  (char_value),
        .line_length (line_length),
        .last        (last)
    );

    // every request yields at least one result, so the block is busy right after
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block ready right after taking a request");

    // a request is never taken while a result is being loaded
    a_no_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !cmd.load)
        else $error("output load during request accept");

    // after the final result of a request the block is ready again
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.last) |=> !in_stall)
        else $error("block not ready after final result");

    // a committed line never exceeds the buffer
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == rcsp_pkg::EV_DONE)
            |-> (line_length <= rcsp_pkg::FILL_W'(LINE_CHARS)))
        else $error("line length beyond buffer size");

endmodule

`default_nettype wire
